@@ rtl/aqfp_pkg.sv @@
`timescale 1ns / 1ps
// package for the adaptive quality frame pacer
// holds widths, register indexes, request modes and shared types; no dependencies

package aqfp_pkg;

  // overflow history depth and count width
  localparam int unsigned WINDOW  = 20;
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);

  // field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 32;
  localparam int unsigned QUAL_W  = 7;
  localparam int unsigned TICK_W  = 8;
  localparam int unsigned THR_W   = 5;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_A_W = 3;

  // fixed values
  localparam logic [QUAL_W-1:0] FULL_QUALITY = QUAL_W'(100);
  localparam logic [TICK_W-1:0] TICK_SAT     = '1;

  // configuration register reset values
  localparam logic [TICK_W-1:0] RST_SEND_INTERVAL = TICK_W'(4);
  localparam logic [TICK_W-1:0] RST_MAX_PENDING   = TICK_W'(3);
  localparam logic [THR_W-1:0]  RST_HIGH_COUNT    = THR_W'(10);
  localparam logic [THR_W-1:0]  RST_LOW_COUNT     = THR_W'(8);
  localparam logic [QUAL_W-1:0] RST_QUALITY_STEP  = QUAL_W'(1);
  localparam logic [QUAL_W-1:0] RST_MIN_QUALITY   = QUAL_W'(10);
  localparam logic [QUAL_W-1:0] RST_MAX_QUALITY   = QUAL_W'(100);

  // configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_SEND_INTERVAL = 3'd0,
    CFG_MAX_PENDING   = 3'd1,
    CFG_HIGH_COUNT    = 3'd2,
    CFG_LOW_COUNT     = 3'd3,
    CFG_QUALITY_STEP  = 3'd4,
    CFG_MIN_QUALITY   = 3'd5,
    CFG_MAX_QUALITY   = 3'd6
  } cfg_idx_e;

  // request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_FULLQ = 2'd2
  } mode_e;

  // push of one overflow bit into the window
  typedef struct packed {
    logic en;
    logic ovf;
  } push_t;

endpackage

@@ rtl/aqfp_if.sv @@
`timescale 1ns / 1ps
// request and result channel interfaces for the frame pacer
// depends on aqfp_pkg for field widths

interface aqfp_req_if;
  import aqfp_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic                source_selected;
  logic                source_known;
  logic                new_frame;
  logic [IDX_W-1:0]    confirmed_number;

  modport source (output valid, mode, source_selected, source_known, new_frame,
                  confirmed_number, input ready);
  modport sink   (input valid, mode, source_selected, source_known, new_frame,
                  confirmed_number, output ready);
endinterface

interface aqfp_res_if;
  import aqfp_pkg::*;
  logic                valid;
  logic                ready;
  logic                send;
  logic                full_quality;
  logic [QUAL_W-1:0]   quality;
  logic [IDX_W-1:0]    frame_index;
  logic                overflow;

  modport source (output valid, send, full_quality, quality, frame_index, overflow,
                  input ready);
  modport sink   (input valid, send, full_quality, quality, frame_index, overflow,
                  output ready);
endinterface

@@ rtl/adaptive_quality_frame_pacer_top.sv @@
`timescale 1ns / 1ps
// top level of the adaptive quality frame pacer
// depends on aqfp_pkg, aqfp_if and aqfp_window

// Usage
//   req_if carries ticks, acknowledgements and full-quality frame requests;
//   res_if returns exactly one result per request, in order.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the seven pacing registers; write
//   them only while no request is in flight.
// Timing and throughput
//   a request is decided in the cycle it is accepted; its result is in the
//   output register the cycle after; one request per cycle unless stalled.
//   The overflow history is a row of WINDOW one-bit cells shifting on each
//   paced check, with a running count beside it, so no step iterates.
// Reset
//   history cleared, quality at full, sent count zero, confirmed count all
//   ones, tick counter saturated; registers return to their defaults.
// Stall
//   while a result waits in the output register, a new request is still
//   taken in the cycle the receiver takes the waiting one; otherwise
//   req_if.ready drops until the result register is free.

module adaptive_quality_frame_pacer_top
  import aqfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  aqfp_req_if.sink           req_if,
  aqfp_res_if.source         res_if,
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i
);

  // configuration registers
  logic [TICK_W-1:0] send_interval_q, max_pending_q;
  logic [THR_W-1:0]  high_count_q, low_count_q;
  logic [QUAL_W-1:0] quality_step_q, min_quality_q, max_quality_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_interval_q <= RST_SEND_INTERVAL;
      max_pending_q   <= RST_MAX_PENDING;
      high_count_q    <= RST_HIGH_COUNT;
      low_count_q     <= RST_LOW_COUNT;
      quality_step_q  <= RST_QUALITY_STEP;
      min_quality_q   <= RST_MIN_QUALITY;
      max_quality_q   <= RST_MAX_QUALITY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEND_INTERVAL: send_interval_q <= cfg_wdata_i;
        CFG_MAX_PENDING:   max_pending_q   <= cfg_wdata_i;
        CFG_HIGH_COUNT:    high_count_q    <= cfg_wdata_i[THR_W-1:0];
        CFG_LOW_COUNT:     low_count_q     <= cfg_wdata_i[THR_W-1:0];
        CFG_QUALITY_STEP:  quality_step_q  <= cfg_wdata_i[QUAL_W-1:0];
        CFG_MIN_QUALITY:   min_quality_q   <= cfg_wdata_i[QUAL_W-1:0];
        CFG_MAX_QUALITY:   max_quality_q   <= cfg_wdata_i[QUAL_W-1:0];
        default: ;
      endcase
    end
  end

  // pacing state
  logic [QUAL_W-1:0] quality_q, quality_d;
  logic [IDX_W-1:0]  sent_q, sent_d;
  logic [IDX_W-1:0]  confirmed_q, confirmed_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;

  // result register
  logic              res_valid_q, res_valid_d;
  logic              res_send_q, res_send_d;
  logic              res_full_q, res_full_d;
  logic [QUAL_W-1:0] res_qual_q, res_qual_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic              res_ovf_q, res_ovf_d;

  logic              accept;
  logic              available;
  logic [TICK_W-1:0] ticks_inc;
  logic              check;
  logic              credit_ovf;
  logic              send;
  push_t             push;
  logic [CNT_W-1:0]  count_next;
  logic [8:0]        qual_adj;
  logic [8:0]        qual_lo;
  logic [QUAL_W-1:0] qual_new;
  logic [7:0]        cnt_ext;

  assign req_if.ready = !res_valid_q || res_if.ready;
  assign accept       = req_if.valid && req_if.ready;
  assign available    = req_if.source_selected && req_if.source_known;

  // tick counter and credit check
  assign ticks_inc  = (ticks_q != TICK_SAT) ? ticks_q + TICK_W'(1) : ticks_q;
  assign check      = req_if.source_selected && (ticks_inc >= send_interval_q);
  assign credit_ovf = (confirmed_q + IDX_W'(max_pending_q)) <= sent_q;

  // window push on every paced check of an accepted tick
  assign push = '{en: accept && (req_if.mode == MODE_TICK) && check, ovf: credit_ovf};

  aqfp_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .count_next_o (count_next)
  );

  // quality adjust from the updated window count, then clamp min before max
  assign cnt_ext = 8'(count_next);
  always_comb begin
    if (cnt_ext > 8'(high_count_q)) begin
      qual_adj = 9'(quality_q) - 9'(quality_step_q);
    end else if (cnt_ext < 8'(low_count_q)) begin
      qual_adj = 9'(quality_q) + 9'(quality_step_q);
    end else begin
      qual_adj = 9'(quality_q);
    end
    qual_lo = ($signed(qual_adj) < $signed(9'(min_quality_q))) ? 9'(min_quality_q)
                                                              : qual_adj;
    qual_new = ($signed(qual_lo) > $signed(9'(max_quality_q))) ? max_quality_q
                                                              : qual_lo[QUAL_W-1:0];
    quality_d = push.en ? qual_new : quality_q;
  end

  // request decode
  always_comb begin
    send        = 1'b0;
    res_full_d  = 1'b0;
    res_qual_d  = '0;
    res_ovf_d   = 1'b0;
    ticks_d     = ticks_q;
    confirmed_d = confirmed_q;
    if (accept) begin
      case (req_if.mode)
        MODE_TICK: begin
          ticks_d = ticks_inc;
          if (check) begin
            if (credit_ovf) begin
              res_ovf_d = 1'b1;
            end else begin
              ticks_d = '0;
              // a paced frame uses the quality after this window update
              if (req_if.new_frame) begin
                send       = 1'b1;
                res_qual_d = available ? qual_new : FULL_QUALITY;
              end
            end
          end
        end
        MODE_ACK: begin
          confirmed_d = req_if.confirmed_number;
        end
        MODE_FULLQ: begin
          if (available || req_if.new_frame) begin
            send       = 1'b1;
            res_full_d = 1'b1;
            res_qual_d = FULL_QUALITY;
          end
        end
        default: ;
      endcase
    end
    res_send_d  = send;
    res_idx_d   = send ? sent_q : '0;
    sent_d      = send ? sent_q + IDX_W'(1) : sent_q;
    res_valid_d = accept || (res_valid_q && !res_if.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quality_q   <= RST_MAX_QUALITY;
      sent_q      <= '0;
      confirmed_q <= '1;
      ticks_q     <= TICK_SAT;
      res_valid_q <= 1'b0;
    end else begin
      quality_q   <= quality_d;
      sent_q      <= sent_d;
      confirmed_q <= confirmed_d;
      ticks_q     <= ticks_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload loads on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_send_q <= res_send_d;
      res_full_q <= res_full_d;
      res_qual_q <= res_qual_d;
      res_idx_q  <= res_idx_d;
      res_ovf_q  <= res_ovf_d;
    end
  end

  assign res_if.valid        = res_valid_q;
  assign res_if.send         = res_send_q;
  assign res_if.full_quality = res_full_q;
  assign res_if.quality      = res_qual_q;
  assign res_if.frame_index  = res_idx_q;
  assign res_if.overflow     = res_ovf_q;

endmodule

@@ rtl/aqfp_cell.sv @@
`timescale 1ns / 1ps
// one window cell: holds one overflow bit and hands it on when the row shifts
// depends on aqfp_pkg

module aqfp_cell
  import aqfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic bit_i,
  output logic bit_o
);

  logic bit_q, bit_d;

  // take the neighbor's bit on a shift
  assign bit_d = shift_i ? bit_i : bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

@@ rtl/aqfp_window.sv @@
`timescale 1ns / 1ps
// overflow history: a row of WINDOW cells plus a running count of ones
// depends on aqfp_pkg and aqfp_cell

module aqfp_window
  import aqfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  output logic [CNT_W-1:0] count_next_o
);

  logic [WINDOW:0]  chain;
  logic [CNT_W-1:0] count_q, count_d;

  // newest bit enters at the head, oldest leaves at the tail
  assign chain[0] = push_i.ovf;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    aqfp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (push_i.en),
      .bit_i   (chain[g]),
      .bit_o   (chain[g+1])
    );
  end

  // count after this push, used by the quality update in the same cycle
  always_comb begin
    count_next_o = count_q - CNT_W'(chain[WINDOW]) + CNT_W'(push_i.ovf);
    count_d      = push_i.en ? count_next_o : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

@@ bench/adaptive_quality_frame_pacer_top_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for adaptive_quality_frame_pacer_top
// depends on aqfp_pkg, aqfp_if and the pacer rtl; drives requests, predicts and checks results

module adaptive_quality_frame_pacer_top_tb;
  import aqfp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              sel;
    logic              known;
    logic              fresh;
    logic [IDX_W-1:0]  confirmed;
  } pacer_req_t;

  typedef struct packed {
    logic              send;
    logic              full_quality;
    logic [QUAL_W-1:0] quality;
    logic [IDX_W-1:0]  frame_index;
    logic              overflow;
  } pacer_res_t;

  typedef struct packed {
    pacer_req_t req;
    logic       typed;
    pacer_res_t res;
  } dir_row_t;

  typedef struct packed {
    logic [TICK_W-1:0] interval;
    logic [TICK_W-1:0] pending;
    logic [THR_W-1:0]  high;
    logic [THR_W-1:0]  low;
    logic [QUAL_W-1:0] step;
    logic [QUAL_W-1:0] minq;
    logic [QUAL_W-1:0] maxq;
  } pace_cfg_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_A_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]   cfg_wdata_i;

  aqfp_req_if req_if ();
  aqfp_res_if res_if ();

  adaptive_quality_frame_pacer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_if     (req_if),
    .res_if     (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // predictor state and register copy
  pace_cfg_t          cfg;
  logic               ovf_hist [WINDOW];
  int                 hist_cnt;
  int                 hist_ptr;
  logic [QUAL_W-1:0]  cur_quality;
  logic [IDX_W-1:0]   sent_cnt;
  logic [IDX_W-1:0]   confirmed_cnt;
  logic [TICK_W-1:0]  ticks_cnt;

  pacer_res_t         due_results_q [$];
  int                 err_cnt = 0;
  int                 req_gap_pct = 0;
  int                 res_stall_pct = 0;
  int                 stall_left = 0;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void pacer_reset();
    cfg = '{RST_SEND_INTERVAL, RST_MAX_PENDING, RST_HIGH_COUNT, RST_LOW_COUNT,
            RST_QUALITY_STEP, RST_MIN_QUALITY, RST_MAX_QUALITY};
    foreach (ovf_hist[k]) ovf_hist[k] = 1'b0;
    hist_cnt      = 0;
    hist_ptr      = 0;
    cur_quality   = RST_MAX_QUALITY;
    sent_cnt      = '0;
    confirmed_cnt = '1;
    ticks_cnt     = TICK_SAT;
  endfunction

  // overflow history update and quality steering
  function automatic void push_history(logic ovf);
    int q;
    hist_cnt = hist_cnt - int'(ovf_hist[hist_ptr]) + int'(ovf);
    ovf_hist[hist_ptr] = ovf;
    hist_ptr = (hist_ptr + 1) % WINDOW;
    q = int'(cur_quality);
    if (hist_cnt > int'(cfg.high)) q -= int'(cfg.step);
    else if (hist_cnt < int'(cfg.low)) q += int'(cfg.step);
    if (q < int'(cfg.minq)) q = int'(cfg.minq);
    if (q > int'(cfg.maxq)) q = int'(cfg.maxq);
    cur_quality = QUAL_W'(q);
  endfunction

  // expected result of one request, state advanced
  function automatic pacer_res_t pace_request(pacer_req_t r);
    pacer_res_t res;
    logic       avail;
    res   = '0;
    avail = r.sel && r.known;
    case (r.mode)
      MODE_TICK: begin
        if (ticks_cnt != TICK_SAT) ticks_cnt = ticks_cnt + 1'b1;
        if (r.sel && ticks_cnt >= cfg.interval) begin
          if (IDX_W'(confirmed_cnt + IDX_W'(cfg.pending)) <= sent_cnt) begin
            push_history(1'b1);
            res.overflow = 1'b1;
          end else begin
            push_history(1'b0);
            if (r.fresh) begin
              res.send        = 1'b1;
              res.quality     = avail ? cur_quality : FULL_QUALITY;
              res.frame_index = sent_cnt;
              sent_cnt        = sent_cnt + 1'b1;
            end
            ticks_cnt = '0;
          end
        end
      end
      MODE_ACK: confirmed_cnt = r.confirmed;
      MODE_FULLQ: begin
        if (avail || r.fresh) begin
          res.send         = 1'b1;
          res.full_quality = 1'b1;
          res.quality      = FULL_QUALITY;
          res.frame_index  = sent_cnt;
          sent_cnt         = sent_cnt + 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic dir_row_t mk_row(logic [MODE_W-1:0] mode, logic sel, logic known,
                                      logic fresh, logic [IDX_W-1:0] conf, logic typed,
                                      logic send, logic full, logic [QUAL_W-1:0] q,
                                      logic [IDX_W-1:0] idx, logic ovf);
    dir_row_t row;
    row.req   = '{mode, sel, known, fresh, conf};
    row.typed = typed;
    row.res   = '{send, full, q, idx, ovf};
    return row;
  endfunction

  // one request through the handshake, expectation queued on acceptance
  task automatic issue_request(pacer_req_t r, logic typed, pacer_res_t typed_res);
    pacer_res_t p;
    req_if.valid            <= 1'b1;
    req_if.mode             <= r.mode;
    req_if.source_selected  <= r.sel;
    req_if.source_known     <= r.known;
    req_if.new_frame        <= r.fresh;
    req_if.confirmed_number <= r.confirmed;
    do @(posedge clk_i); while (!req_if.ready);
    p = pace_request(r);
    due_results_q.push_back(typed ? typed_res : p);
    if ($urandom_range(0, 99) < req_gap_pct) begin
      req_if.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (due_results_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // write all seven registers while idle
  task automatic load_config(pace_cfg_t c);
    logic [CFG_W-1:0] vals [7];
    vals = '{CFG_W'(c.interval), CFG_W'(c.pending), CFG_W'(c.high), CFG_W'(c.low),
             CFG_W'(c.step), CFG_W'(c.minq), CFG_W'(c.maxq)};
    for (int k = 0; k < 7; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(k);
      cfg_wdata_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg = c;
  endtask

  // random stalls on the result side
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < res_stall_pct) begin
      stall_left   <= pick_gap() - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : res_check
    pacer_res_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (due_results_q.size() == 0) begin
        $error("result with no request outstanding");
        err_cnt++;
      end else begin
        want = due_results_q.pop_front();
        check_field("send", want.send, res_if.send);
        check_field("full_quality", want.full_quality, res_if.full_quality);
        check_field("quality", want.quality, res_if.quality);
        check_field("frame_index", want.frame_index, res_if.frame_index);
        check_field("overflow", want.overflow, res_if.overflow);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("adaptive_quality_frame_pacer_top_tb NOT OK");
    $finish;
  end

  initial begin
    dir_row_t   dir_tab [$];
    pace_cfg_t  phases [8];
    int         gap_pcts [8];
    int         stall_pcts [8];
    pacer_req_t r;
    int         pick;

    req_if.valid            = 1'b0;
    req_if.mode             = MODE_TICK;
    req_if.source_selected  = 1'b0;
    req_if.source_known     = 1'b0;
    req_if.new_frame        = 1'b0;
    req_if.confirmed_number = '0;
    res_if.ready            = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = CFG_SEND_INTERVAL;
    cfg_wdata_i             = '0;
    rst_ni                  = 1'b0;
    pacer_reset();

    // directed rows, reset defaults: interval 4, two frames in flight allowed
    dir_tab.push_back(mk_row(MODE_TICK,  1, 1, 1, 32'h0, 1, 1, 0, 100, 0, 0));
    dir_tab.push_back(mk_row(MODE_TICK,  1, 1, 1, 32'h0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_FULLQ, 1, 1, 0, 32'h0, 1, 1, 1, 100, 1, 0));
    dir_tab.push_back(mk_row(MODE_FULLQ, 0, 0, 0, 32'h0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_FULLQ, 0, 1, 1, 32'h0, 1, 1, 1, 100, 2, 0));
    dir_tab.push_back(mk_row(MODE_TICK,  1, 1, 1, 32'h0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_TICK,  1, 1, 1, 32'h0, 1, 0, 0, 0, 0, 0));
    // confirmed count still all ones: credit exhausted
    dir_tab.push_back(mk_row(MODE_TICK,  1, 1, 1, 32'h0, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(MODE_TICK,  1, 1, 1, 32'h0, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(MODE_ACK,   0, 0, 0, 32'h0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_TICK,  1, 1, 1, 32'h0, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(MODE_ACK,   1, 1, 1, '1, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_TICK,  1, 1, 1, '1, 1, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(MODE_ACK,   0, 0, 0, 32'd2, 1, 0, 0, 0, 0, 0));
    // unavailable source sends at full quality
    dir_tab.push_back(mk_row(MODE_TICK,  1, 0, 1, 32'h0, 1, 1, 0, 100, 3, 0));
    dir_tab.push_back(mk_row(MODE_TICK,  0, 1, 1, 32'h0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_TICK,  0, 1, 1, 32'h0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_TICK,  0, 1, 1, 32'h0, 1, 0, 0, 0, 0, 0));
    // paced check with nothing new still restarts the interval
    dir_tab.push_back(mk_row(MODE_TICK,  1, 1, 0, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_TICK,  1, 1, 1, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_UNUSED, 1, 1, 1, 32'h1234_5678, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_FULLQ, 1, 0, 0, 32'h0, 1, 0, 0, 0, 0, 0));

    // setting phases: extremes first, then random ones
    phases[0] = '{8'd4, 8'd3, 5'd10, 5'd8, 7'd1, 7'd10, 7'd100};
    phases[1] = '{8'd1, 8'd1, 5'd2, 5'd1, 7'd5, 7'd0, 7'd100};
    phases[2] = '{8'd2, 8'd255, 5'd20, 5'd0, 7'd100, 7'd0, 7'd0};
    phases[3] = '{8'd1, 8'd4, 5'd10, 5'd8, 7'd3, 7'd50, 7'd40};
    phases[4] = '{8'd255, 8'd2, 5'd0, 5'd20, 7'd1, 7'd100, 7'd100};
    gap_pcts   = '{0, 30, 10, 40, 5, 0, 0, 0};
    stall_pcts = '{0, 30, 50, 10, 5, 0, 0, 0};
    for (int p = 5; p < 8; p++) begin
      phases[p] = '{TICK_W'($urandom_range(1, 8)), TICK_W'($urandom_range(1, 12)),
                    THR_W'($urandom_range(0, 20)), THR_W'($urandom_range(0, 20)),
                    QUAL_W'($urandom_range(1, 20)), QUAL_W'($urandom_range(0, 100)),
                    QUAL_W'($urandom_range(0, 100))};
      gap_pcts[p]   = $urandom_range(0, 50);
      stall_pcts[p] = $urandom_range(0, 50);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    req_gap_pct   = 20;
    res_stall_pct = 20;
    foreach (dir_tab[k]) issue_request(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].res);
    drain_results();

    // random traffic: mostly selected ticks and acks near the sent count
    for (int p = 0; p < 8; p++) begin
      drain_results();
      load_config(phases[p]);
      req_gap_pct   = gap_pcts[p];
      res_stall_pct = stall_pcts[p];
      for (int n = 0; n < 240; n++) begin
        pick        = $urandom_range(0, 99);
        r.sel       = ($urandom_range(0, 9) != 0);
        r.known     = ($urandom_range(0, 9) != 0);
        r.fresh     = ($urandom_range(0, 3) != 0);
        r.confirmed = $urandom;
        if (pick < 60) begin
          r.mode = MODE_TICK;
        end else if (pick < 80) begin
          r.mode = MODE_ACK;
          if ($urandom_range(0, 9) != 0)
            r.confirmed = sent_cnt - IDX_W'($urandom_range(0, int'(cfg.pending) + 2));
        end else if (pick < 98) begin
          r.mode  = MODE_FULLQ;
          r.sel   = $urandom_range(0, 1);
          r.known = $urandom_range(0, 1);
          r.fresh = $urandom_range(0, 1);
        end else begin
          r.mode = MODE_UNUSED;
        end
        issue_request(r, 1'b0, '0);
        // hold off the sender until every result is back
        if (p == 3 && n == 120) drain_results();
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("adaptive_quality_frame_pacer_top_tb OK");
    end else begin
      $display("adaptive_quality_frame_pacer_top_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/aqfp_pkg.sv
rtl/aqfp_if.sv
rtl/aqfp_cell.sv
rtl/aqfp_window.sv
rtl/adaptive_quality_frame_pacer_top.sv
bench/adaptive_quality_frame_pacer_top_tb.sv
